/* rtl/pdmc_pkg.sv */
// Shared types and constants of the pinned direct-mapped cache policy block.
// No dependencies; the files that use it refer to it by scoped names.
package pdmc_pkg;

  localparam int SLOTS     = 256;
  localparam int SLOT_BITS = $clog2(SLOTS);
  localparam int PIN_BITS  = 16;
  localparam int GEN_BITS  = 64;
  localparam int HGT_BITS  = 32;
  localparam int HASH_BITS = 256;

  localparam logic [PIN_BITS-1:0] PIN_MAX = {PIN_BITS{1'b1}};
  localparam logic [SLOT_BITS-1:0] SLOT_LAST = SLOT_BITS'(SLOTS - 1);

  typedef enum logic [2:0] {
    CMD_LOOKUP  = 3'd0,
    CMD_FILL    = 3'd1,
    CMD_RELEASE = 3'd2,
    CMD_EVICT   = 3'd3,
    CMD_CLEAR   = 3'd4
  } cmd_t;

  typedef enum logic [3:0] {
    ST_HIT       = 4'd0,
    ST_MISS      = 4'd1,
    ST_INSTALLED = 4'd2,
    ST_RACE_HIT  = 4'd3,
    ST_DETACHED  = 4'd4,
    ST_RELEASED  = 4'd5,
    ST_REL_IGN   = 4'd6,
    ST_EVICTED   = 4'd7,
    ST_EVICT_DEF = 4'd8,
    ST_EVICT_NM  = 4'd9,
    ST_CLEARED   = 4'd10,
    ST_PIN_FULL  = 4'd11
  } status_t;

  // Per-slot policy state; reads as all zero until the slot is first written.
  typedef struct packed {
    logic                valid;
    logic                pending;
    logic [GEN_BITS-1:0] gen;
    logic [PIN_BITS-1:0] pins;
  } meta_t;

  // Stored key of a slot; only looked at while the slot is valid.
  typedef struct packed {
    logic [HGT_BITS-1:0]  height;
    logic [HASH_BITS-1:0] hash;
  } key_t;

  localparam int META_BITS = $bits(meta_t);
  localparam int KEY_BITS  = $bits(key_t);

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic capture;
    logic rd_en;
    logic rd_clr;
    logic commit;
    logic clr_commit;
    logic emit_clear;
  } ctl_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic in_is_clear;
    logic clr_last;
    logic out_free;
  } sts_t;

endpackage

/* rtl/pdmc_in_if.sv */
// Request channel of the cache policy block: valid, ready and the request fields.
// Depends on nothing.
interface pdmc_in_if;
  logic               valid;
  logic               ready;
  logic [2:0]         command;
  logic signed [31:0] height;
  logic [63:0]        hash_word0;
  logic [63:0]        hash_word1;
  logic [63:0]        hash_word2;
  logic [63:0]        hash_word3;
  logic               fetch_matches;
  logic [7:0]         release_slot;
  logic [63:0]        release_generation;
  logic               release_detached;

  modport source (
    output valid, command, height, hash_word0, hash_word1, hash_word2, hash_word3,
           fetch_matches, release_slot, release_generation, release_detached,
    input  ready
  );
  modport sink (
    input  valid, command, height, hash_word0, hash_word1, hash_word2, hash_word3,
           fetch_matches, release_slot, release_generation, release_detached,
    output ready
  );
endinterface

/* rtl/pdmc_out_if.sv */
// Result channel of the cache policy block: valid, ready and the result fields.
// Depends on nothing.
interface pdmc_out_if;
  logic        valid;
  logic        ready;
  logic [3:0]  status;
  logic [7:0]  slot;
  logic [63:0] generation;
  logic        is_detached;

  modport source (output valid, status, slot, generation, is_detached, input ready);
  modport sink   (input valid, status, slot, generation, is_detached, output ready);
endinterface

/* rtl/pinned_direct_mapped_cache_policy.sv */
// Tag and policy store of a direct-mapped cache with per-slot pin counts.
// Each request is accepted in the idle state, during which the slot's policy and key
// entries are read from RAM; then, in the update state, the slot is written and the
// result is loaded into the output register, so lookup, fill, release and evict each
// pass through accept and update, set by the single read-then-write of the slot RAMs.
// A result may wait in the output register while the next request is accepted; a
// request stalls in its update state only while a previous result is still untaken.
// Clear sweeps every slot with a read state and a write state per slot, then emits
// its result from a final state. The slot RAMs need no clearing pass after reset: a
// per-slot written flag, cleared by reset, makes untouched slots read as empty.
// Depends on pdmc_pkg, pdmc_in_if, pdmc_out_if, pdmc_ctrl and pdmc_dp.
module pinned_direct_mapped_cache_policy (
  input  logic       clk,
  input  logic       rst_n,
  pdmc_in_if.sink    in_ch,
  pdmc_out_if.source out_ch
);

  pdmc_pkg::ctl_t ctl;
  pdmc_pkg::sts_t sts;
  logic           in_ready;

  pdmc_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_ch.valid),
    .in_ready (in_ready),
    .sts      (sts),
    .ctl      (ctl)
  );

  pdmc_dp u_dp (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch),
    .ctl    (ctl),
    .sts    (sts)
  );

  assign in_ch.ready = in_ready;

endmodule

/* rtl/pdmc_ram.sv */
// Generic simple dual-port RAM: one write port, one read port with registered data.
// No dependencies.
module pdmc_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_r[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data_r <= mem_r[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

/* rtl/pdmc_ctrl.sv */
// Controller of the cache policy block: sequences accept, slot update and the clear sweep.
// Depends on pdmc_pkg.
module pdmc_ctrl (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_valid,
  output logic          in_ready,
  input  pdmc_pkg::sts_t sts,
  output pdmc_pkg::ctl_t ctl
);

  typedef enum logic [4:0] {
    S_IDLE   = 5'b00001,
    S_EXEC   = 5'b00010,
    S_CLR_RD = 5'b00100,
    S_CLR_WR = 5'b01000,
    S_CLR_FN = 5'b10000
  } state_t;

  state_t state_r, state_nxt;

  always_comb begin
    state_nxt = state_r;
    ctl       = '0;
    in_ready  = 1'b0;
    case (state_r)
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          ctl.capture = 1'b1;
          ctl.rd_en   = 1'b1;
          state_nxt   = sts.in_is_clear ? S_CLR_RD : S_EXEC;
        end
      end
      S_EXEC: begin
        // The slot update and the result go out together, once the output is free.
        if (sts.out_free) begin
          ctl.commit = 1'b1;
          state_nxt  = S_IDLE;
        end
      end
      S_CLR_RD: begin
        ctl.rd_en  = 1'b1;
        ctl.rd_clr = 1'b1;
        state_nxt  = S_CLR_WR;
      end
      S_CLR_WR: begin
        ctl.clr_commit = 1'b1;
        state_nxt      = sts.clr_last ? S_CLR_FN : S_CLR_RD;
      end
      S_CLR_FN: begin
        if (sts.out_free) begin
          ctl.emit_clear = 1'b1;
          state_nxt      = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

/* rtl/pdmc_dp.sv */
// Datapath of the cache policy block: request registers, slot memories, generation
// counter, per-command update logic and the result register. Depends on pdmc_pkg,
// pdmc_in_if, pdmc_out_if and pdmc_ram.
module pdmc_dp (
  input  logic           clk,
  input  logic           rst_n,
  pdmc_in_if.sink        in_ch,
  pdmc_out_if.source     out_ch,
  input  pdmc_pkg::ctl_t ctl,
  output pdmc_pkg::sts_t sts
);

  localparam int SB = pdmc_pkg::SLOT_BITS;
  localparam int PB = pdmc_pkg::PIN_BITS;
  localparam int GB = pdmc_pkg::GEN_BITS;

  // Latched request.
  logic [2:0]                      req_cmd_r;
  logic [pdmc_pkg::HGT_BITS-1:0]   req_height_r;
  logic [pdmc_pkg::HASH_BITS-1:0]  req_hash_r;
  logic                            req_fetch_r;
  logic [GB-1:0]                   req_rel_gen_r;
  logic                            req_rel_det_r;
  logic [SB-1:0]                   req_addr_r;

  logic [SB-1:0]                   clr_idx_r;
  logic [GB-1:0]                   gen_ctr_r;
  logic [pdmc_pkg::SLOTS-1:0]      init_r;
  logic                            init_q_r;

  logic                            out_valid_r;
  logic [3:0]                      out_status_r;
  logic [7:0]                      out_slot_r;
  logic [GB-1:0]                   out_gen_r;
  logic                            out_det_r;

  logic [SB-1:0]                   in_addr;
  logic [SB-1:0]                   rd_addr;
  logic [SB-1:0]                   wr_addr;
  logic [pdmc_pkg::META_BITS-1:0]  meta_q;
  logic [pdmc_pkg::KEY_BITS-1:0]   key_q;
  pdmc_pkg::meta_t                 meta;
  pdmc_pkg::key_t                  key;
  pdmc_pkg::meta_t                 meta_wr;
  pdmc_pkg::meta_t                 clr_wr;
  pdmc_pkg::key_t                  key_wr;
  logic                            meta_we;
  logic                            key_we;
  logic                            ctr_inc;
  logic                            clr_we;
  logic                            clr_inc;
  logic                            meta_wr_en;
  logic [GB-1:0]                   gen_next;
  logic                            key_eq;
  logic                            hit;
  logic                            pin_full;
  logic [PB-1:0]                   pins_dec;
  logic [3:0]                      o_status;
  logic [7:0]                      o_slot;
  logic [GB-1:0]                   o_gen;
  logic                            o_det;

  assign in_addr = (in_ch.command == pdmc_pkg::CMD_RELEASE) ? SB'(in_ch.release_slot)
                                                             : in_ch.height[SB-1:0];
  assign rd_addr = ctl.rd_clr ? clr_idx_r : in_addr;
  assign wr_addr = ctl.clr_commit ? clr_idx_r : req_addr_r;

  pdmc_ram #(.WIDTH(pdmc_pkg::META_BITS), .DEPTH(pdmc_pkg::SLOTS)) u_meta_ram (
    .clk     (clk),
    .wr_en   (meta_wr_en),
    .wr_addr (wr_addr),
    .wr_data (ctl.clr_commit ? clr_wr : meta_wr),
    .rd_en   (ctl.rd_en),
    .rd_addr (rd_addr),
    .rd_data (meta_q)
  );

  pdmc_ram #(.WIDTH(pdmc_pkg::KEY_BITS), .DEPTH(pdmc_pkg::SLOTS)) u_key_ram (
    .clk     (clk),
    .wr_en   (ctl.commit & key_we),
    .wr_addr (req_addr_r),
    .wr_data (key_wr),
    .rd_en   (ctl.rd_en),
    .rd_addr (rd_addr),
    .rd_data (key_q)
  );

  // A slot never written since reset reads as its reset value, all zero.
  assign meta     = init_q_r ? pdmc_pkg::meta_t'(meta_q) : '0;
  assign key      = pdmc_pkg::key_t'(key_q);
  assign gen_next = gen_ctr_r + GB'(1);
  assign key_eq   = (key.height == req_height_r) && (key.hash == req_hash_r);
  assign hit      = meta.valid && !meta.pending && key_eq;
  assign pin_full = (meta.pins == pdmc_pkg::PIN_MAX);
  assign pins_dec = meta.pins - PB'(1);

  assign key_wr.height = req_height_r;
  assign key_wr.hash   = req_hash_r;

  always_comb begin
    meta_wr  = meta;
    meta_we  = 1'b0;
    key_we   = 1'b0;
    ctr_inc  = 1'b0;
    o_status = pdmc_pkg::ST_REL_IGN;
    o_slot   = 8'(req_addr_r);
    o_gen    = '0;
    o_det    = 1'b0;
    case (req_cmd_r)
      pdmc_pkg::CMD_LOOKUP, pdmc_pkg::CMD_FILL: begin
        if ((req_cmd_r == pdmc_pkg::CMD_FILL) && !req_fetch_r) begin
          ctr_inc  = 1'b1;
          o_status = pdmc_pkg::ST_DETACHED;
          o_gen    = gen_next;
          o_det    = 1'b1;
        end else if (hit) begin
          if (pin_full) begin
            o_status = pdmc_pkg::ST_PIN_FULL;
          end else begin
            meta_wr.pins = meta.pins + PB'(1);
            meta_we      = 1'b1;
            o_status     = (req_cmd_r == pdmc_pkg::CMD_FILL) ? pdmc_pkg::ST_RACE_HIT
                                                              : pdmc_pkg::ST_HIT;
            o_gen        = meta.gen;
          end
        end else if (req_cmd_r == pdmc_pkg::CMD_LOOKUP) begin
          o_status = pdmc_pkg::ST_MISS;
        end else if (!meta.valid || (meta.pins == '0)) begin
          meta_wr.valid   = 1'b1;
          meta_wr.pending = 1'b0;
          meta_wr.gen     = gen_next;
          meta_wr.pins    = PB'(1);
          meta_we         = 1'b1;
          key_we          = 1'b1;
          ctr_inc         = 1'b1;
          o_status        = pdmc_pkg::ST_INSTALLED;
          o_gen           = gen_next;
        end else begin
          // Slot pinned by another key or by a pending entry: hand out a detached entry.
          ctr_inc  = 1'b1;
          o_status = pdmc_pkg::ST_DETACHED;
          o_gen    = gen_next;
          o_det    = 1'b1;
        end
      end
      pdmc_pkg::CMD_RELEASE: begin
        if (req_rel_det_r) begin
          o_status = pdmc_pkg::ST_RELEASED;
        end else if ((meta.gen == req_rel_gen_r) && (meta.pins != '0)) begin
          meta_wr.pins = pins_dec;
          meta_we      = 1'b1;
          if ((pins_dec == '0) && meta.pending) begin
            meta_wr.valid   = 1'b0;
            meta_wr.pending = 1'b0;
            meta_wr.gen     = gen_next;
            ctr_inc         = 1'b1;
          end
          o_status = pdmc_pkg::ST_RELEASED;
        end else begin
          o_status = pdmc_pkg::ST_REL_IGN;
        end
      end
      pdmc_pkg::CMD_EVICT: begin
        if (meta.valid && key_eq) begin
          meta_we = 1'b1;
          if (meta.pins == '0) begin
            meta_wr.valid   = 1'b0;
            meta_wr.pending = 1'b0;
            meta_wr.gen     = gen_next;
            ctr_inc         = 1'b1;
            o_status        = pdmc_pkg::ST_EVICTED;
          end else begin
            meta_wr.pending = 1'b1;
            o_status        = pdmc_pkg::ST_EVICT_DEF;
          end
        end else begin
          o_status = pdmc_pkg::ST_EVICT_NM;
        end
      end
      default: begin
        o_slot = '0;
      end
    endcase
  end

  // One slot of the clear sweep: mark pending, free it at once if nothing pins it.
  always_comb begin
    clr_wr  = meta;
    clr_we  = meta.valid;
    clr_inc = 1'b0;
    if (meta.valid) begin
      clr_wr.pending = 1'b1;
      if (meta.pins == '0) begin
        clr_wr.valid   = 1'b0;
        clr_wr.pending = 1'b0;
        clr_wr.gen     = gen_next;
        clr_inc        = 1'b1;
      end
    end
  end

  assign meta_wr_en = (ctl.commit & meta_we) | (ctl.clr_commit & clr_we);

  always_ff @(posedge clk) begin
    if (ctl.capture) begin
      req_cmd_r     <= in_ch.command;
      req_height_r  <= in_ch.height;
      req_hash_r    <= {in_ch.hash_word3, in_ch.hash_word2,
                        in_ch.hash_word1, in_ch.hash_word0};
      req_fetch_r   <= in_ch.fetch_matches;
      req_rel_gen_r <= in_ch.release_generation;
      req_rel_det_r <= in_ch.release_detached;
      req_addr_r    <= in_addr;
    end
    if (ctl.rd_en) begin
      init_q_r <= init_r[rd_addr];
    end
    if (ctl.commit || ctl.emit_clear) begin
      out_status_r <= ctl.emit_clear ? pdmc_pkg::ST_CLEARED : o_status;
      out_slot_r   <= ctl.emit_clear ? 8'd0 : o_slot;
      out_gen_r    <= ctl.emit_clear ? '0 : o_gen;
      out_det_r    <= ctl.emit_clear ? 1'b0 : o_det;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      gen_ctr_r   <= '0;
      init_r      <= '0;
      clr_idx_r   <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if ((ctl.commit && ctr_inc) || (ctl.clr_commit && clr_inc)) begin
        gen_ctr_r <= gen_next;
      end
      if (meta_wr_en) begin
        init_r[wr_addr] <= 1'b1;
      end
      if (ctl.capture) begin
        clr_idx_r <= '0;
      end else if (ctl.clr_commit) begin
        clr_idx_r <= clr_idx_r + SB'(1);
      end
      if (ctl.commit || ctl.emit_clear) begin
        out_valid_r <= 1'b1;
      end else if (out_ch.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  assign sts.in_is_clear = (in_ch.command == pdmc_pkg::CMD_CLEAR);
  assign sts.clr_last    = (clr_idx_r == pdmc_pkg::SLOT_LAST);
  assign sts.out_free    = !out_valid_r || out_ch.ready;

  assign out_ch.valid       = out_valid_r;
  assign out_ch.status      = out_status_r;
  assign out_ch.slot        = out_slot_r;
  assign out_ch.generation  = out_gen_r;
  assign out_ch.is_detached = out_det_r;

endmodule

/* bench/testbench.sv */
`timescale 1ns / 100ps
// Self-checking bench for pinned_direct_mapped_cache_policy: directed and random request
// traffic, checked against a slot-by-slot model. Uses pdmc_pkg, pdmc_in_if, pdmc_out_if.
module testbench;

  localparam int SB = pdmc_pkg::SLOT_BITS;
  localparam int PB = pdmc_pkg::PIN_BITS;
  localparam logic [2:0] CMD_SPARE_LO = 3'd5;
  localparam logic [2:0] CMD_SPARE_HI = 3'd7;
  localparam int KEYS = 20;
  localparam int GROUPS = 6;
  localparam int MAX_GAP = 18;
  localparam int REPORT_LIMIT = 10;
  localparam int STALL_LIMIT = 5000;
  localparam int RANDOM_ITEMS = 420;
  localparam int HANDLE_CAP = 48;
  localparam int TAIL_CYCLES = 20;

  typedef struct {
    logic [2:0]       command;
    logic [31:0]      height;
    logic [3:0][63:0] hash;
    logic             fetch_matches;
    logic [7:0]       release_slot;
    logic [63:0]      release_generation;
    logic             release_detached;
    int               gap;
  } request_t;

  typedef struct packed {
    logic [3:0]  status;
    logic [7:0]  slot;
    logic [63:0] generation;
    logic        is_detached;
  } outcome_t;

  typedef struct packed {
    logic [7:0]  slot;
    logic [63:0] gen;
    logic        det;
  } handle_t;

  typedef struct packed {
    logic [31:0]      height;
    logic [3:0][63:0] hash;
  } cache_key_t;

  logic clk = 1'b0;
  logic rst_n;

  pdmc_in_if  in_ch ();
  pdmc_out_if out_ch ();

  pinned_direct_mapped_cache_policy dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  always #10 clk = ~clk;

  // Model of the slot store.
  logic             ent_valid   [pdmc_pkg::SLOTS];
  logic             ent_pending [pdmc_pkg::SLOTS];
  logic [31:0]      ent_height  [pdmc_pkg::SLOTS];
  logic [3:0][63:0] ent_hash    [pdmc_pkg::SLOTS];
  logic [63:0]      ent_gen     [pdmc_pkg::SLOTS];
  logic [PB-1:0]    ent_pins    [pdmc_pkg::SLOTS];
  logic [63:0]      gen_count;

  outcome_t   policy_outcomes[$];
  handle_t    held_handles[$];
  request_t   stim_q[$];
  cache_key_t keys[KEYS];

  request_t staged, on_bus;
  bit       staged_ok;
  int       staged_wait;
  int       stall_left;
  int       idle_cycles;
  int       fail_count = 0;
  bit       calm = 1'b0;

  function automatic logic [63:0] rand64();
    return {$urandom(), $urandom()};
  endfunction

  function automatic logic [63:0] next_gen();
    gen_count = gen_count + 64'd1;
    return gen_count;
  endfunction

  function automatic void free_slot(input logic [SB-1:0] s);
    ent_valid[s]   = 1'b0;
    ent_pending[s] = 1'b0;
    ent_gen[s]     = next_gen();
  endfunction

  task automatic pin_entry(input logic [SB-1:0] s, input pdmc_pkg::status_t on_hit,
                           output outcome_t o);
    o = '0;
    o.slot = 8'(s);
    if (ent_pins[s] == pdmc_pkg::PIN_MAX) begin
      o.status = pdmc_pkg::ST_PIN_FULL;
    end else begin
      ent_pins[s]  = ent_pins[s] + 1'b1;
      o.status     = on_hit;
      o.generation = ent_gen[s];
    end
  endtask

  // Applies one accepted request to the model and queues the answer it must produce.
  task automatic apply_cache_policy(input request_t r);
    logic [SB-1:0] s, rs;
    logic          key_eq, hit;
    outcome_t      o;
    s      = r.height[SB-1:0];
    rs     = r.release_slot[SB-1:0];
    key_eq = ent_valid[s] && ent_height[s] == r.height && ent_hash[s] == r.hash;
    hit    = key_eq && !ent_pending[s];
    o      = '0;
    o.slot = 8'(s);
    case (r.command)
      pdmc_pkg::CMD_LOOKUP: begin
        if (hit) pin_entry(s, pdmc_pkg::ST_HIT, o);
        else o.status = pdmc_pkg::ST_MISS;
      end
      pdmc_pkg::CMD_FILL: begin
        if (!r.fetch_matches) begin
          o.status = pdmc_pkg::ST_DETACHED;
          o.generation = next_gen();
          o.is_detached = 1'b1;
        end else if (hit) begin
          pin_entry(s, pdmc_pkg::ST_RACE_HIT, o);
        end else if (!ent_valid[s] || ent_pins[s] == '0) begin
          ent_valid[s]   = 1'b1;
          ent_pending[s] = 1'b0;
          ent_height[s]  = r.height;
          ent_hash[s]    = r.hash;
          ent_gen[s]     = next_gen();
          ent_pins[s]    = PB'(1);
          o.status       = pdmc_pkg::ST_INSTALLED;
          o.generation   = ent_gen[s];
        end else begin
          // Slot is held by another key or a pending entry: serve the fetch outside the ring.
          o.status = pdmc_pkg::ST_DETACHED;
          o.generation = next_gen();
          o.is_detached = 1'b1;
        end
      end
      pdmc_pkg::CMD_RELEASE: begin
        o.slot = 8'(rs);
        if (r.release_detached) begin
          o.status = pdmc_pkg::ST_RELEASED;
        end else if (ent_gen[rs] == r.release_generation && ent_pins[rs] != '0) begin
          ent_pins[rs] = ent_pins[rs] - 1'b1;
          if (ent_pins[rs] == '0 && ent_pending[rs]) free_slot(rs);
          o.status = pdmc_pkg::ST_RELEASED;
        end else begin
          o.status = pdmc_pkg::ST_REL_IGN;
        end
      end
      pdmc_pkg::CMD_EVICT: begin
        // Pending entries still match an evict.
        if (key_eq) begin
          ent_pending[s] = 1'b1;
          if (ent_pins[s] == '0) begin
            free_slot(s);
            o.status = pdmc_pkg::ST_EVICTED;
          end else begin
            o.status = pdmc_pkg::ST_EVICT_DEF;
          end
        end else begin
          o.status = pdmc_pkg::ST_EVICT_NM;
        end
      end
      pdmc_pkg::CMD_CLEAR: begin
        for (int i = 0; i < pdmc_pkg::SLOTS; i++) begin
          if (ent_valid[i]) begin
            ent_pending[i] = 1'b1;
            if (ent_pins[i] == '0) free_slot(SB'(i));
          end
        end
        o.status = pdmc_pkg::ST_CLEARED;
        o.slot = '0;
      end
      default: begin
        o.status = pdmc_pkg::ST_REL_IGN;
        o.slot = '0;
      end
    endcase
    policy_outcomes.push_back(o);
    if (o.status inside {pdmc_pkg::ST_HIT, pdmc_pkg::ST_INSTALLED, pdmc_pkg::ST_RACE_HIT,
                         pdmc_pkg::ST_DETACHED}) begin
      if (held_handles.size() >= HANDLE_CAP) void'(held_handles.pop_front());
      held_handles.push_back('{slot: o.slot, gen: o.generation, det: o.is_detached});
    end
  endtask

  // Request driver.
  always @(posedge clk) begin
    if (!rst_n) begin
      in_ch.valid <= 1'b0;
      staged_ok = 1'b0;
      gen_count = '0;
      for (int i = 0; i < pdmc_pkg::SLOTS; i++) begin
        ent_valid[i]   = 1'b0;
        ent_pending[i] = 1'b0;
        ent_height[i]  = '0;
        ent_hash[i]    = '0;
        ent_gen[i]     = '0;
        ent_pins[i]    = '0;
      end
    end else begin
      if (in_ch.valid && in_ch.ready) apply_cache_policy(on_bus);
      if (!in_ch.valid || in_ch.ready) begin
        if (!staged_ok && stim_q.size() > 0) begin
          staged = stim_q.pop_front();
          staged_ok = 1'b1;
          staged_wait = staged.gap;
        end
        if (staged_ok && staged_wait == 0) begin
          in_ch.command            <= staged.command;
          in_ch.height             <= staged.height;
          in_ch.hash_word0         <= staged.hash[0];
          in_ch.hash_word1         <= staged.hash[1];
          in_ch.hash_word2         <= staged.hash[2];
          in_ch.hash_word3         <= staged.hash[3];
          in_ch.fetch_matches      <= staged.fetch_matches;
          in_ch.release_slot       <= staged.release_slot;
          in_ch.release_generation <= staged.release_generation;
          in_ch.release_detached   <= staged.release_detached;
          in_ch.valid              <= 1'b1;
          on_bus = staged;
          staged_ok = 1'b0;
        end else begin
          if (staged_ok) staged_wait--;
          in_ch.valid <= 1'b0;
        end
      end
    end
  end

  // Result monitor.
  always @(posedge clk) begin
    outcome_t exp_o;
    if (!rst_n) begin
      out_ch.ready <= 1'b0;
      stall_left = 0;
    end else begin
      if (out_ch.valid && out_ch.ready) begin
        if (policy_outcomes.size() == 0) begin
          fail_count++;
          if (fail_count <= REPORT_LIMIT)
            $display("%0t: result with no request outstanding: status %0d slot %0d",
                     $realtime, out_ch.status, out_ch.slot);
        end else begin
          exp_o = policy_outcomes.pop_front();
          if (out_ch.status !== exp_o.status || out_ch.slot !== exp_o.slot ||
              out_ch.generation !== exp_o.generation ||
              out_ch.is_detached !== exp_o.is_detached) begin
            fail_count++;
            if (fail_count <= REPORT_LIMIT)
              $display("%0t: mismatch: expected %0d %0d %0h %0b, got %0d %0d %0h %0b",
                       $realtime, exp_o.status, exp_o.slot, exp_o.generation,
                       exp_o.is_detached, out_ch.status, out_ch.slot, out_ch.generation,
                       out_ch.is_detached);
          end
        end
        stall_left = calm ? 0 : $urandom_range(0, MAX_GAP);
      end
      if (stall_left > 0) begin
        stall_left--;
        out_ch.ready <= 1'b0;
      end else begin
        out_ch.ready <= 1'b1;
      end
    end
  end

  // Watchdog on cycles without any handshake.
  always @(posedge clk) begin
    if (!rst_n) begin
      idle_cycles = 0;
    end else if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) begin
      idle_cycles = 0;
    end else begin
      idle_cycles++;
      if (idle_cycles >= STALL_LIMIT) begin
        $display("testbench: FAIL");
        $finish;
      end
    end
  end

  initial begin
    rst_n = 1'b0;
    in_ch.valid = 1'b0;
    in_ch.command = '0;
    in_ch.height = '0;
    in_ch.hash_word0 = '0;
    in_ch.hash_word1 = '0;
    in_ch.hash_word2 = '0;
    in_ch.hash_word3 = '0;
    in_ch.fetch_matches = 1'b0;
    in_ch.release_slot = '0;
    in_ch.release_generation = '0;
    in_ch.release_detached = 1'b0;
    out_ch.ready = 1'b0;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
  end

  function automatic request_t rand_req();
    request_t r;
    r.command            = 3'($urandom_range(0, 7));
    r.height             = $urandom();
    for (int w = 0; w < 4; w++) r.hash[w] = rand64();
    r.fetch_matches      = 1'($urandom_range(0, 1));
    r.release_slot       = 8'($urandom());
    r.release_generation = rand64();
    r.release_detached   = 1'($urandom_range(0, 1));
    r.gap                = calm ? 0 : $urandom_range(0, MAX_GAP);
    return r;
  endfunction

  function automatic request_t keyed_req(input pdmc_pkg::cmd_t c, input cache_key_t k,
                                         input bit fm);
    request_t r;
    r = rand_req();
    r.command = c;
    r.height = k.height;
    r.hash = k.hash;
    r.fetch_matches = fm;
    return r;
  endfunction

  function automatic request_t release_req(input handle_t h);
    request_t r;
    r = rand_req();
    r.command = pdmc_pkg::CMD_RELEASE;
    r.release_slot = h.slot;
    r.release_generation = h.gen;
    r.release_detached = h.det;
    return r;
  endfunction

  task automatic send(input request_t r);
    stim_q.push_back(r);
    while (stim_q.size() >= 2) @(negedge clk);
  endtask

  // Waits until every queued request has been taken by the block.
  task automatic settle();
    do @(negedge clk); while (stim_q.size() != 0 || staged_ok || in_ch.valid);
  endtask

  initial begin
    logic [7:0] group_slot[GROUPS];
    cache_key_t k0, k1, kb, kc;
    handle_t    h0, h1, h;
    request_t   r;
    int         pick, idx;

    group_slot[0] = 8'h00;
    group_slot[1] = 8'hFF;
    for (int g = 2; g < GROUPS; g++) group_slot[g] = 8'(g * 37 + $urandom_range(0, 30));
    for (int k = 0; k < KEYS; k++) begin
      keys[k].height = {24'($urandom()), group_slot[k % GROUPS]};
      for (int w = 0; w < 4; w++) keys[k].hash[w] = rand64();
      // Near neighbors: same height with one hash bit off, or same hash at another height.
      if (k >= GROUPS && (k / GROUPS) % 2 == 1) begin
        keys[k].height = keys[k - GROUPS].height;
        keys[k].hash = keys[k - GROUPS].hash;
        keys[k].hash[$urandom_range(0, 3)][$urandom_range(0, 63)] ^= 1'b1;
      end else if (k >= GROUPS) begin
        keys[k].hash = keys[k - GROUPS].hash;
      end
    end

    while (!rst_n) @(negedge clk);

    // Directed part.
    k0 = keys[0];
    k1 = keys[1];
    kb = k0;
    kb.height[31] = ~kb.height[31];
    kc = k0;
    kc.hash[3][$urandom_range(0, 63)] ^= 1'b1;
    send(keyed_req(pdmc_pkg::CMD_LOOKUP, k0, 1'b1));
    send(keyed_req(pdmc_pkg::CMD_EVICT, k0, 1'b1));
    send(release_req('{slot: 8'h00, gen: 64'd0, det: 1'b0}));
    send(release_req('{slot: 8'hFF, gen: rand64(), det: 1'b1}));
    send(keyed_req(pdmc_pkg::CMD_FILL, k0, 1'b0));
    send(keyed_req(pdmc_pkg::CMD_FILL, k0, 1'b1));
    settle();
    h0 = held_handles[$];
    send(keyed_req(pdmc_pkg::CMD_LOOKUP, k0, 1'b1));
    send(keyed_req(pdmc_pkg::CMD_FILL, k0, 1'b1));
    send(keyed_req(pdmc_pkg::CMD_FILL, kb, 1'b1));
    send(keyed_req(pdmc_pkg::CMD_LOOKUP, kc, 1'b1));
    send(keyed_req(pdmc_pkg::CMD_EVICT, kb, 1'b1));
    send(keyed_req(pdmc_pkg::CMD_EVICT, k0, 1'b1));
    send(keyed_req(pdmc_pkg::CMD_LOOKUP, k0, 1'b1));
    // Three pins are held on a pending entry; the third release frees the slot and a fourth is ignored.
    repeat (3) send(release_req(h0));
    send(release_req(h0));
    send(keyed_req(pdmc_pkg::CMD_FILL, k1, 1'b1));
    settle();
    h1 = held_handles[$];
    send(release_req(h1));
    send(keyed_req(pdmc_pkg::CMD_EVICT, k1, 1'b1));
    send(keyed_req(pdmc_pkg::CMD_FILL, k0, 1'b1));
    send(keyed_req(pdmc_pkg::CMD_FILL, k1, 1'b1));
    r = rand_req();
    r.command = pdmc_pkg::CMD_CLEAR;
    send(r);
    r = rand_req();
    r.command = CMD_SPARE_LO;
    send(r);
    r = rand_req();
    r.command = CMD_SPARE_HI;
    send(r);
    r = keyed_req(pdmc_pkg::CMD_LOOKUP, '{height: 32'h7FFF_FFFF, hash: '1}, 1'b1);
    send(r);
    r = keyed_req(pdmc_pkg::CMD_FILL, '{height: 32'h8000_0000, hash: '0}, 1'b1);
    send(r);
    settle();
    while (policy_outcomes.size() != 0) @(negedge clk);
    held_handles.delete();

    // Random part: mostly requests on a small set of colliding keys.
    for (int n = 0; n < RANDOM_ITEMS; n++) begin
      if (n % 30 == 0) calm = ($urandom_range(0, 3) == 0);
      pick = $urandom_range(0, 99);
      if (pick < 25) begin
        r = keyed_req(pdmc_pkg::CMD_LOOKUP, keys[$urandom_range(0, KEYS - 1)], 1'b1);
      end else if (pick < 50) begin
        r = keyed_req(pdmc_pkg::CMD_FILL, keys[$urandom_range(0, KEYS - 1)],
                      $urandom_range(0, 9) != 0);
      end else if (pick < 72 && held_handles.size() > 0) begin
        idx = $urandom_range(0, held_handles.size() - 1);
        h = held_handles[idx];
        if ($urandom_range(0, 99) < 85) held_handles.delete(idx);
        if ($urandom_range(0, 9) == 0) h.gen[$urandom_range(0, 63)] ^= 1'b1;
        if ($urandom_range(0, 19) == 0) h.det = ~h.det;
        if ($urandom_range(0, 19) == 0) h.slot = 8'($urandom());
        r = release_req(h);
      end else if (pick < 84) begin
        r = keyed_req(pdmc_pkg::CMD_EVICT, keys[$urandom_range(0, KEYS - 1)], 1'b1);
      end else if (pick < 86) begin
        r = rand_req();
        r.command = pdmc_pkg::CMD_CLEAR;
      end else begin
        r = rand_req();
      end
      send(r);
    end

    calm = 1'b0;
    settle();
    while (policy_outcomes.size() != 0) @(negedge clk);
    repeat (TAIL_CYCLES) @(negedge clk);
    if (fail_count == 0) begin
      $display("testbench: PASS");
    end else begin
      $display("testbench: FAIL");
    end
    $finish;
  end

endmodule
